### src/ftbl_pkg.sv
`timescale 1ns / 1ps

package ftbl_pkg;

   // Full channel value, also the opaque alpha.
   localparam logic [7:0] CH_MAX = 8'hFF;

   // Channel index of the alpha byte within an ARGB word.
   localparam logic [1:0] ALPHA_IDX = 2'd3;

   // Reset value of the background color register (opaque black).
   localparam logic [31:0] BG_RESET = 32'hFF000000;

   // Reciprocal of 255*255 for exact floor division of values below 2**24.
   localparam int          RECIP_SHIFT = 40;
   localparam logic [24:0] RECIP_MULT  = 25'd16909061;

   // One channel request sent to the shared blend unit.
   typedef struct packed {
      logic       valid;
      logic [1:0] idx;
   } issue_type;

   // One channel result returned by the shared blend unit.
   typedef struct packed {
      logic       valid;
      logic [1:0] idx;
      logic [7:0] q;
   } result_type;

   // Sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_WEIGHT = 6'b000010,
      ST_CALC   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_DONE   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

endpackage

### src/ftbl_blend_unit.sv
`timescale 1ns / 1ps

module ftbl_blend_unit
   import ftbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  issue_type   issue,
   input  logic [7:0]  cf,
   input  logic [7:0]  cb,
   input  logic [15:0] wf,
   input  logic [15:0] wb,
   output result_type  rslt
);

   logic [23:0] v_ff;
   logic [23:0] v_in;
   logic [1:0]  idx1_ff;
   logic        vld1_ff;
   logic [7:0]  q_ff;
   logic [7:0]  q_in;
   logic [1:0]  idx2_ff;
   logic        vld2_ff;
   logic [24:0] sum_full;
   logic [48:0] prod_full;

   // First stage: weighted sum of front and back channel, at most 255**3.
   always_comb begin
      sum_full = ({17'd0, cf} * {9'd0, wf}) + ({17'd0, cb} * {9'd0, wb});
      v_in     = sum_full[23:0];
   end

   // Second stage: divide by 255*255 through the reciprocal.
   always_comb begin
      prod_full = {25'd0, v_ff} * {24'd0, RECIP_MULT};
      q_in      = prod_full[RECIP_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= issue.valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      idx1_ff <= issue.idx;
      q_ff    <= q_in;
      idx2_ff <= idx1_ff;
   end

   assign rslt.valid = vld2_ff;
   assign rslt.idx   = idx2_ff;
   assign rslt.q     = q_ff;

`ifndef ASSERT_OFF
   // Every issued channel comes back as a valid result once it has passed the stage registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      issue.valid |=> ##1 rslt.valid)
      else $error("blend unit result missing two cycles after issue");
`endif

endmodule

### src/front_to_back_layer_blender_top.sv
`timescale 1ns / 1ps
// A layer that needs arithmetic holds the block through weighting, the issue of its channels
// and the drain of the blend unit; a fold with a transparent side goes from weighting to done.
// A final layer then waits to hand off its pixel, longer while the previous pixel is
// stalled; a translucent pixel first gets a background fold. Layers are taken only while
// idle, paced by the one shared two-stage unit that computes the four channels in turn.
// Reset is synchronous, active high: it clears the accumulator and output valid.

module front_to_back_layer_blender_top
   import ftbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_layer_color,
   input  logic        req_last_layer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_color,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   state_type   state_ff, state_in;
   logic [31:0] bg_color_ff, bg_color_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] op_front_ff, op_front_in;
   logic [31:0] op_back_ff, op_back_in;
   logic [31:0] res_ff, res_in;
   logic [15:0] wf_ff, wf_in;
   logic [15:0] wb_ff, wb_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        bg_ff, bg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pixel_ff, rsp_pixel_in;

   issue_type   issue;
   result_type  rslt;
   logic [7:0]  cf, cb;
   logic [7:0]  af, ab;
   logic        req_accept;
   logic        out_free;

   assign af         = op_front_ff[31:24];
   assign ab         = op_back_ff[31:24];
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Channel operands for the shared unit; alpha uses the full channel value on both sides.
   always_comb begin
      case (cnt_ff)
         2'd0:    begin cf = op_front_ff[7:0];   cb = op_back_ff[7:0];   end
         2'd1:    begin cf = op_front_ff[15:8];  cb = op_back_ff[15:8];  end
         2'd2:    begin cf = op_front_ff[23:16]; cb = op_back_ff[23:16]; end
         default: begin cf = CH_MAX;             cb = CH_MAX;            end
      endcase
   end

   assign issue.valid = (state_ff == ST_CALC);
   assign issue.idx   = cnt_ff;

   ftbl_blend_unit u_blend (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .cf    (cf),
      .cb    (cb),
      .wf    (wf_ff),
      .wb    (wb_ff),
      .rslt  (rslt)
   );

   // Sequencer for one fold, the optional background fold and the output hand-off.
   always_comb begin
      state_in     = state_ff;
      bg_color_in  = bg_color_ff;
      acc_in       = acc_ff;
      op_front_in  = op_front_ff;
      op_back_in   = op_back_ff;
      res_in       = res_ff;
      wf_in        = wf_ff;
      wb_in        = wb_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      bg_in        = bg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;

      if (csr_valid && csr_ready) begin
         bg_color_in = csr_data;
      end

      // Channel results land in the result word as they return.
      if (rslt.valid) begin
         res_in[{rslt.idx, 3'b000} +: 8] = rslt.q;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_front_in = acc_ff;
               op_back_in  = req_layer_color;
               last_in     = req_last_layer;
               bg_in       = 1'b0;
               state_in    = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            // A transparent side passes the other one through unchanged.
            if (af == 8'd0) begin
               res_in   = op_back_ff;
               state_in = ST_DONE;
            end else if (ab == 8'd0) begin
               res_in   = op_front_ff;
               state_in = ST_DONE;
            end else begin
               wf_in    = {af, 8'd0} - {8'd0, af};
               wb_in    = {8'd0, ab} * {8'd0, CH_MAX - af};
               cnt_in   = 2'd0;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == ALPHA_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rslt.valid && (rslt.idx == ALPHA_IDX)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!bg_ff && !last_ff) begin
               acc_in   = res_ff;
               state_in = ST_IDLE;
            end else if (!bg_ff && (res_ff[31:24] != CH_MAX)) begin
               op_front_in = res_ff;
               op_back_in  = bg_color_ff;
               bg_in       = 1'b1;
               state_in    = ST_WEIGHT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
               acc_in       = 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bg_color_ff  <= BG_RESET;
         acc_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
         last_ff      <= 1'b0;
         bg_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bg_color_ff  <= bg_color_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         bg_ff        <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_front_ff  <= op_front_in;
      op_back_ff   <= op_back_in;
      res_ff       <= res_in;
      wf_ff        <= wf_in;
      wb_ff        <= wb_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_pixel_ff;

`ifndef ASSERT_OFF
   // Channel results only return while a fold is computing.
   a_rslt_in_fold: assert property (@(posedge clock) disable iff (reset)
      rslt.valid |-> (state_ff == ST_CALC || state_ff == ST_DRAIN))
      else $error("blend result outside of a fold");

   // A pixel skips the background only when it is already opaque.
   a_opaque_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !bg_ff) |-> (res_ff[31:24] == CH_MAX))
      else $error("translucent pixel emitted without background");

   // Handing off a pixel presents it and clears the accumulator.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && acc_ff == 32'd0))
      else $error("pixel hand-off did not clear the accumulator");
`endif

endmodule

### sim/front_to_back_layer_blender_top_tb.sv
`timescale 1ns / 1ps

module front_to_back_layer_blender_top_tb;
   import ftbl_pkg::*;

   // Cycles to let the block settle before a register write or the end of the run.
   localparam int DRAIN_CYCLES   = 24;
   // Length of the long output hold-off and the phase in which it happens.
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_PHASE     = 2;
   // Phase in which the sender waits for every pixel once.
   localparam int PAUSE_PHASE    = 4;
   // Phase with no idling on either side.
   localparam int CALM_PHASE     = 0;
   localparam int PHASE_COUNT    = 8;
   localparam int LAYERS_A_PHASE = 200;
   localparam int DIRECTED_COUNT = 20;

   // One directed layer; the pixel is typed in only where it is obvious.
   typedef struct packed {
      logic [31:0] color;
      logic        last;
      logic        typed;
      logic [31:0] pixel;
   } layer_row_type;

   localparam layer_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{32'hFF123456, 1'b1, 1'b1, 32'hFF123456},  // opaque single layer
      '{32'h00000000, 1'b1, 1'b1, 32'hFF000000},  // all zero: background shows
      '{32'h00ABCDEF, 1'b1, 1'b1, 32'hFF000000},  // transparent with color bits
      '{32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF},  // all ones
      '{32'hFF112233, 1'b0, 1'b0, 32'h0},
      '{32'h80FFFFFF, 1'b1, 1'b1, 32'hFF112233},  // opaque front hides the rest
      '{32'h00FFFFFF, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 1'b0, 1'b0, 32'h0},
      '{32'h7F808080, 1'b1, 1'b0, 32'h0},
      '{32'h01FFFFFF, 1'b0, 1'b0, 32'h0},
      '{32'h01FFFFFF, 1'b0, 1'b0, 32'h0},
      '{32'hFE000000, 1'b1, 1'b0, 32'h0},
      '{32'h80FF0000, 1'b0, 1'b0, 32'h0},
      '{32'h8000FF00, 1'b0, 1'b0, 32'h0},
      '{32'h800000FF, 1'b1, 1'b0, 32'h0},
      '{32'hFF000000, 1'b0, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 1'b1, 1'b1, 32'hFF000000},  // opaque black stays black
      '{32'h40AA5533, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 1'b0, 1'b0, 32'h0},         // transparent layer keeps the sum
      '{32'hC0FFFFFF, 1'b1, 1'b0, 32'h0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_layer_color;
   logic        req_last_layer;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_pixel_color;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   // Predictor state and the pixels it still expects.
   logic [31:0] acc_color;
   logic [31:0] bg_color;
   logic [31:0] expected_pixels [$];

   int error_count    = 0;
   int pixels_checked = 0;
   int total_layers   = 0;
   int bg_writes      = 0;
   int phase_no       = -1;
   bit hold_done      = 1'b0;

   front_to_back_layer_blender_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_layer_color (req_layer_color),
      .req_last_layer  (req_last_layer),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Over blend of one ARGB color on top of another, truncating at each divide.
   function automatic logic [31:0] blend_over(input logic [31:0] front, input logic [31:0] back);
      logic [31:0] af;
      logic [31:0] ab;
      logic [31:0] rest;
      logic [31:0] mix;
      logic [31:0] res;
      af = {24'd0, front[31:24]};
      ab = {24'd0, back[31:24]};
      if (af == 0) return back;
      if (ab == 0) return front;
      rest = 32'(CH_MAX) - af;
      res = '0;
      res[31:24] = 8'((af * 32'(CH_MAX) + ab * rest) / 32'(CH_MAX));
      for (int lane = 0; lane < 3; lane++) begin
         mix = {24'd0, front[lane*8 +: 8]} * af * 32'(CH_MAX)
             + {24'd0, back[lane*8 +: 8]} * ab * rest;
         res[lane*8 +: 8] = 8'(mix / 32'(CH_MAX) / 32'(CH_MAX));
      end
      return res;
   endfunction

   // Folds one accepted layer into the running color; returns 1 when a pixel is finished.
   function automatic logic fold_layer(input logic [31:0] color, input logic last,
                                       output logic [31:0] pixel);
      acc_color = blend_over(acc_color, color);
      pixel = acc_color;
      if (!last) return 1'b0;
      if (pixel[31:24] != CH_MAX) pixel = blend_over(pixel, bg_color);
      acc_color = '0;
      return 1'b1;
   endfunction

   // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random layer with alpha biased toward transparent, opaque and the edges.
   function automatic logic [31:0] random_layer();
      int r;
      logic [7:0] alpha;
      r = $urandom_range(0, 9);
      if (r < 2) alpha = 8'h00;
      else if (r < 4) alpha = 8'hFF;
      else if (r < 5) alpha = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE;
      else alpha = 8'($urandom_range(0, 255));
      return {alpha, 24'($urandom)};
   endfunction

   // Offers one layer request, waits for it to be taken and records the expected pixel.
   task automatic send_layer(input logic [31:0] color, input logic last, input logic typed,
                             input logic [31:0] typed_pixel, input int gap);
      logic [31:0] pixel;
      logic        done;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_layer_color <= color;
      req_last_layer  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      done = fold_layer(color, last, pixel);
      if (done) expected_pixels.push_back(typed ? typed_pixel : pixel);
      total_layers++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops offering requests and waits until the block has nothing left to deliver.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the background color register while the block is idle.
   task automatic write_background(input logic [31:0] value);
      drain_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      bg_color = value;
      bg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, one long hold-off, and a calm phase with none.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_no == HOLD_PHASE && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (phase_no == CALM_PHASE || $urandom_range(0, 99) < 60) begin
            rsp_stall <= 1'b0;
         end else begin
            n = idle_cycles();
            if (n == 0) n = 1;
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // Result checker: every delivered pixel against the oldest expectation.
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel_color: no pixel expected, actual %08h", rsp_pixel_color);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_color !== want) begin
               $error("pixel_color: expected %08h, actual %08h", want, rsp_pixel_color);
               error_count++;
            end
         end
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $error("run timed out with %0d pixels outstanding", expected_pixels.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence: reset, directed rows, then random phases over several backgrounds.
   initial begin
      int layers_done;
      int layer_count;
      int pixel_idx;
      int r;
      int gap;
      logic [31:0] bg_value;
      logic [31:0] color;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_layer_color = '0;
      req_last_layer  = 1'b0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      acc_color       = '0;
      bg_color        = BG_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows with the background left at its reset value.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_layer(DIRECTED_ROWS[i].color, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].pixel, idle_cycles());
      end

      // Random phases, each with its own background and ending on a pixel boundary.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: bg_value = 32'h00000000;
            1: bg_value = 32'hFFFFFFFF;
            2: bg_value = 32'h80FFFFFF;
            3: bg_value = 32'h01000000;
            6: bg_value = BG_RESET;
            default: bg_value = $urandom;
         endcase
         write_background(bg_value);
         phase_no = p;
         layers_done = 0;
         pixel_idx = 0;
         while (layers_done < LAYERS_A_PHASE) begin
            if (p == HOLD_PHASE) begin
               layer_count = 1;
            end else begin
               r = $urandom_range(0, 9);
               if (r < 4) layer_count = 1;
               else if (r < 7) layer_count = 2;
               else if (r < 9) layer_count = 3;
               else layer_count = $urandom_range(4, 8);
            end
            for (int k = 0; k < layer_count; k++) begin
               color = random_layer();
               gap = (p == CALM_PHASE || p == HOLD_PHASE) ? 0 : idle_cycles();
               send_layer(color, (k == layer_count - 1), 1'b0, 32'h0, gap);
               layers_done++;
            end
            pixel_idx++;
            // Once in the run the sender waits until every pixel is out.
            if (p == PAUSE_PHASE && pixel_idx == 20) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (expected_pixels.size() != 0) @(posedge clock);
            end
         end
      end

      drain_block();
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", expected_pixels.size());
         error_count++;
      end
      $display("Run covered %0d layers and %0d checked pixels over %0d background settings,",
               total_layers, pixels_checked, bg_writes + 1);
      $display("with random idling on both sides and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
